@@ design/dtq_pkg.sv @@
// ----------------------------------------------------------------------------
// dtq_pkg
// Shared sizes, codes and controller/datapath bundles of the deadline queue.
// ----------------------------------------------------------------------------
package dtq_pkg;

    localparam int DEPTH     = 16;
    localparam int TIME_BITS = 32;
    localparam int TASK_BITS = 8;
    localparam int MAX_FIRE  = 16;
    localparam int CNT_BITS  = $clog2(DEPTH + 1);
    localparam int FIRE_BITS = $clog2(MAX_FIRE);
    localparam int OP_BITS   = 2;
    localparam int STAT_BITS = 3;

    typedef enum logic [OP_BITS-1:0] {
        OP_ADD    = 2'd0,
        OP_REMOVE = 2'd1,
        OP_TICK   = 2'd2
    } op_t;

    typedef enum logic [STAT_BITS-1:0] {
        ST_ADDED    = 3'd0,
        ST_DUP      = 3'd1,
        ST_FULL     = 3'd2,
        ST_REMOVED  = 3'd3,
        ST_NOTFOUND = 3'd4,
        ST_FIRED    = 3'd5,
        ST_NONEDUE  = 3'd6
    } status_t;

    typedef enum logic [0:0] {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic    capture;
        logic    insert;
        logic    remove;
        logic    pop;
        logic    emit;
        logic    fired;
        logic    last;
        status_t status;
    } dtq_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic [OP_BITS-1:0] op;
        logic               found;
        logic               full;
        logic               head_due;
        logic               next_due;
    } dtq_stat_t;

endpackage

@@ design/dtq_in_if.sv @@
// ----------------------------------------------------------------------------
// dtq_in_if
// Request channel: operation, deadline, task id and present time.
// ----------------------------------------------------------------------------
interface dtq_in_if import dtq_pkg::*; ();

    logic                 valid;
    logic                 ready;
    logic [OP_BITS-1:0]   operation;
    logic [TIME_BITS-1:0] deadline;
    logic [TASK_BITS-1:0] task_id;
    logic [TIME_BITS-1:0] current_time;

    modport source (output valid, operation, deadline, task_id, current_time, input ready);
    modport sink   (input valid, operation, deadline, task_id, current_time, output ready);

endinterface

@@ design/dtq_out_if.sv @@
// ----------------------------------------------------------------------------
// dtq_out_if
// Result channel: status, fired entry and last mark.
// ----------------------------------------------------------------------------
interface dtq_out_if import dtq_pkg::*; ();

    logic                 valid;
    logic                 ready;
    logic [STAT_BITS-1:0] status;
    logic [TASK_BITS-1:0] fired_task;
    logic [TIME_BITS-1:0] fired_deadline;
    logic                 last;

    modport source (output valid, status, fired_task, fired_deadline, last, input ready);
    modport sink   (input valid, status, fired_task, fired_deadline, last, output ready);

endinterface

@@ design/dtq_datapath.sv @@
// ----------------------------------------------------------------------------
// dtq_datapath
// Sorted register row of entries, request latch and result register.
// ----------------------------------------------------------------------------
module dtq_datapath import dtq_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [OP_BITS-1:0]   operation,
    input  logic [TIME_BITS-1:0] deadline,
    input  logic [TASK_BITS-1:0] task_id,
    input  logic [TIME_BITS-1:0] current_time,
    input  dtq_cmd_t             cmd,
    output dtq_stat_t            stat,
    output logic [STAT_BITS-1:0] status,
    output logic [TASK_BITS-1:0] fired_task,
    output logic [TIME_BITS-1:0] fired_deadline,
    output logic                 last
);

    logic [OP_BITS-1:0]   req_op_reg;
    logic [TIME_BITS-1:0] req_dl_reg;
    logic [TASK_BITS-1:0] req_task_reg;
    logic [TIME_BITS-1:0] req_now_reg;

    logic [TIME_BITS-1:0] ent_dl_reg   [DEPTH];
    logic [TASK_BITS-1:0] ent_task_reg [DEPTH];
    logic [TIME_BITS-1:0] ent_dl_next  [DEPTH];
    logic [TASK_BITS-1:0] ent_task_next[DEPTH];
    logic [TIME_BITS-1:0] below_dl     [DEPTH];
    logic [TASK_BITS-1:0] below_task   [DEPTH];
    logic [TIME_BITS-1:0] above_dl     [DEPTH];
    logic [TASK_BITS-1:0] above_task   [DEPTH];

    logic [CNT_BITS-1:0]  count_reg;
    logic [CNT_BITS-1:0]  count_next;

    logic [DEPTH-1:0]     valid_vec;
    logic [DEPTH-1:0]     lt_vec;
    logic [DEPTH-1:0]     eq_vec;
    logic [DEPTH-1:0]     prev_lt;

    status_t              out_status_reg;
    logic [TASK_BITS-1:0] out_task_reg;
    logic [TIME_BITS-1:0] out_dl_reg;
    logic                 out_last_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_op_reg   <= operation;
            req_dl_reg   <= deadline;
            req_task_reg <= task_id;
            req_now_reg  <= current_time;
        end
    end

    // per-entry compare against the latched deadline; valid entries form a prefix
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            valid_vec[i] = CNT_BITS'(i) < count_reg;
            lt_vec[i]    = valid_vec[i] && (ent_dl_reg[i] < req_dl_reg);
            eq_vec[i]    = valid_vec[i] && (ent_dl_reg[i] == req_dl_reg);
        end
    end

    assign prev_lt = {lt_vec[DEPTH-2:0], 1'b1};

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        if (i == 0)
        begin : g_first
            assign below_dl[i]   = req_dl_reg;
            assign below_task[i] = req_task_reg;
        end
        else
        begin : g_mid
            assign below_dl[i]   = ent_dl_reg[i-1];
            assign below_task[i] = ent_task_reg[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_end
            assign above_dl[i]   = ent_dl_reg[i];
            assign above_task[i] = ent_task_reg[i];
        end
        else
        begin : g_inner
            assign above_dl[i]   = ent_dl_reg[i+1];
            assign above_task[i] = ent_task_reg[i+1];
        end

        // insert: hold below the slot, load at it, shift down past it
        // remove/pop: close the gap by taking the next entry up
        always_comb
        begin
            ent_dl_next[i]   = ent_dl_reg[i];
            ent_task_next[i] = ent_task_reg[i];
            if (cmd.insert && !lt_vec[i])
            begin
                if (prev_lt[i])
                begin
                    ent_dl_next[i]   = req_dl_reg;
                    ent_task_next[i] = req_task_reg;
                end
                else
                begin
                    ent_dl_next[i]   = below_dl[i];
                    ent_task_next[i] = below_task[i];
                end
            end
            else if ((cmd.remove && !lt_vec[i]) || cmd.pop)
            begin
                ent_dl_next[i]   = above_dl[i];
                ent_task_next[i] = above_task[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ent_dl_reg   <= ent_dl_next;
        ent_task_reg <= ent_task_next;
    end

    always_comb
    begin
        count_next = count_reg;
        if (cmd.insert)
            count_next = count_reg + CNT_BITS'(1);
        else if (cmd.remove || cmd.pop)
            count_next = count_reg - CNT_BITS'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    assign stat.op       = req_op_reg;
    assign stat.found    = |eq_vec;
    assign stat.full     = count_reg == CNT_BITS'(DEPTH);
    assign stat.head_due = valid_vec[0] && (ent_dl_reg[0] <= req_now_reg);
    assign stat.next_due = valid_vec[1] && (ent_dl_reg[1] <= req_now_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_status_reg <= cmd.status;
            out_task_reg   <= cmd.fired ? ent_task_reg[0] : '0;
            out_dl_reg     <= cmd.fired ? ent_dl_reg[0] : '0;
            out_last_reg   <= cmd.last;
        end
    end

    assign status         = out_status_reg;
    assign fired_task     = out_task_reg;
    assign fired_deadline = out_dl_reg;
    assign last           = out_last_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_BITS'(DEPTH))
        else $error("entry count beyond depth");

    a_no_insert_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.insert |-> !stat.full && !stat.found)
        else $error("insert into full table or duplicate deadline");

    a_pop_due: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop |-> stat.head_due)
        else $error("pop of an entry not due");

    for (genvar i = 0; i < DEPTH - 1; i++)
    begin : g_sorted
        a_sorted: assert property (@(posedge clk) disable iff (!rst_n)
            (CNT_BITS'(i + 1) < count_reg) |-> (ent_dl_reg[i] < ent_dl_reg[i+1]))
            else $error("entry row out of order");
    end

endmodule

@@ design/dtq_ctrl.sv @@
// ----------------------------------------------------------------------------
// dtq_ctrl
// Sequencer: takes one request, runs it on the datapath, hands out results.
// ----------------------------------------------------------------------------
module dtq_ctrl import dtq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    input  dtq_stat_t stat,
    output dtq_cmd_t  cmd
);

    state_t               state_reg;
    state_t               state_next;
    logic [FIRE_BITS-1:0] fire_cnt_reg;
    logic [FIRE_BITS-1:0] fire_cnt_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic                 slot_free;
    logic                 tick_last;

    assign slot_free = !out_valid_reg || out_ready;
    assign tick_last = !stat.head_due || !stat.next_due
                    || (fire_cnt_reg == FIRE_BITS'(MAX_FIRE - 1));

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                    state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if (slot_free && ((stat.op != OP_TICK) || tick_last))
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd         = '0;
        cmd.status  = ST_ADDED;
        in_ready    = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            S_EXEC:
            begin
                if (slot_free)
                begin
                    unique case (stat.op)
                        OP_ADD:
                        begin
                            cmd.emit = 1'b1;
                            cmd.last = 1'b1;
                            if (stat.found)
                                cmd.status = ST_DUP;
                            else if (stat.full)
                                cmd.status = ST_FULL;
                            else
                            begin
                                cmd.status = ST_ADDED;
                                cmd.insert = 1'b1;
                            end
                        end
                        OP_REMOVE:
                        begin
                            cmd.emit   = 1'b1;
                            cmd.last   = 1'b1;
                            cmd.remove = stat.found;
                            cmd.status = stat.found ? ST_REMOVED : ST_NOTFOUND;
                        end
                        OP_TICK:
                        begin
                            cmd.emit = 1'b1;
                            cmd.last = tick_last;
                            if (stat.head_due)
                            begin
                                cmd.status = ST_FIRED;
                                cmd.fired  = 1'b1;
                                cmd.pop    = 1'b1;
                            end
                            else
                                cmd.status = ST_NONEDUE;
                        end
                        default: ;  // unused code: drop silently
                    endcase
                end
            end
            default: ;
        endcase
    end

    always_comb
    begin
        fire_cnt_next = fire_cnt_reg;
        if (cmd.capture)
            fire_cnt_next = '0;
        else if (cmd.pop)
            fire_cnt_next = fire_cnt_reg + FIRE_BITS'(1);
    end

    always_comb
    begin
        if (cmd.emit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fire_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fire_cnt_reg  <= fire_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    a_emit_slot: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!out_valid_reg || out_ready))
        else $error("result overwrites an untaken result");

    a_one_update: assert property (@(posedge clk) disable iff (!rst_n)
        $countones({cmd.insert, cmd.remove, cmd.pop}) <= 1)
        else $error("conflicting table updates");

    a_pop_emits: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop |-> cmd.emit && cmd.fired && (cmd.status == ST_FIRED))
        else $error("pop without a fired result");

    a_capture_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |=> (state_reg == S_EXEC) && (fire_cnt_reg == '0))
        else $error("request not taken into execution");

endmodule

@@ design/deadline_timer_queue.sv @@
// ----------------------------------------------------------------------------
// deadline_timer_queue
// Deadline-ordered task table with add, remove and time-tick firing.
// ----------------------------------------------------------------------------
// One request is taken at a time. An add, a remove, a tick that finds nothing
// due, or an unused operation is latched when it is transferred and is then
// run in the execute step, where a table update compares every entry against
// the deadline at once and shifts the sorted register row by one place. A
// tick that fires n entries (n at most MAX_FIRE) stays in the execute step
// until the last is fired; results leave the head of the row one per cycle
// while the result channel takes them, and each firing shifts the row. A result
// sits in an output register, so the next request is taken while it waits; a
// stalled result channel holds the sequencer in its execute step. Entries never written are never read.
// ----------------------------------------------------------------------------
module deadline_timer_queue import dtq_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    dtq_in_if.sink   req,
    dtq_out_if.source rsp
);

    dtq_cmd_t  cmd;
    dtq_stat_t stat;

    dtq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    dtq_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .operation      (req.operation),
        .deadline       (req.deadline),
        .task_id        (req.task_id),
        .current_time   (req.current_time),
        .cmd            (cmd),
        .stat           (stat),
        .status         (rsp.status),
        .fired_task     (rsp.fired_task),
        .fired_deadline (rsp.fired_deadline),
        .last           (rsp.last)
    );

endmodule
